>>> hw/rtl/tbw_pkg.sv
// shared types, widths and output formatting for the barycentric weight pipeline
package tbw_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NUM_W   = CROSS_W + 2;
    localparam int THR_W   = 20;
    localparam int FRAC_SH = 17;
    localparam int REM_W   = NUM_W + FRAC_SH + 1;
    localparam int DEN_W   = CROSS_W + 1;
    localparam int Q_W     = 33;
    localparam int WIDE_W  = DEN_W + Q_W - 1;
    localparam int W_W     = 32;
    localparam int NLANE   = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);
    localparam logic [W_W-1:0]   ONE_FX    = W_W'(65536);
    localparam logic [W_W-1:0]   SAT_POS   = {1'b0, {(W_W-1){1'b1}}};
    localparam logic [W_W-1:0]   SAT_NEG   = {1'b1, {(W_W-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             zero;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [DEN_W-1:0] den;
        t_lane [NLANE-1:0] lane;
    } t_cell;

    function automatic logic [W_W-1:0] fmt_weight(input t_lane l);
        logic [W_W-1:0] r;
        r = '0;
        if (l.zero) begin
            r = '0;
        end else if (!l.neg) begin
            if (l.ovf || (l.q[Q_W-1:W_W-1] != '0)) r = SAT_POS;
            else r = l.q[W_W-1:0];
        end else begin
            if (l.ovf || (l.q[Q_W-1] && (l.q[W_W-1:0] != '0)) || l.q[Q_W-1:0] > {1'b0, SAT_NEG})
                r = SAT_NEG;
            else r = W_W'(~l.q[W_W-1:0] + W_W'(1));
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/tbw_front.sv
// difference, cross product and dividend setup stages
module tbw_front import tbw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_p_x,
    input  logic signed [COORD_W-1:0] i_p_y,
    input  logic [THR_W-1:0]          i_thr,
    output t_cell                     o_cell
);
    logic                      r_v0, r_v1, r_v2;
    logic signed [DIFF_W-1:0]  r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic signed [PROD_W-1:0]  r_m [6];
    logic signed [CROSS_W-1:0] r_cu, r_cv, r_area;
    logic signed [NUM_W-1:0]   r_numa;
    logic                      r_degen;
    t_cell                     r_cell, n_cell;

    logic signed [CROSS_W-1:0] n_cu, n_cv, n_area;
    logic [CROSS_W-1:0]        n_mag;
    logic                      n_degen;

    function automatic logic signed [DIFF_W-1:0] sub16(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    always_comb begin
        n_cu    = CROSS_W'(r_m[0]) - CROSS_W'(r_m[1]);
        n_cv    = CROSS_W'(r_m[2]) - CROSS_W'(r_m[3]);
        n_area  = CROSS_W'(r_m[4]) - CROSS_W'(r_m[5]);
        n_mag   = n_area[CROSS_W-1] ? CROSS_W'(-n_area) : CROSS_W'(n_area);
        n_degen = (n_area == '0) || (n_mag < CROSS_W'(i_thr));
    end

    always_comb begin
        logic signed [NUM_W-1:0] num [NLANE];
        logic [NUM_W-1:0]        mag;
        logic [CROSS_W-1:0]      md;
        logic [REM_W-1:0]        nn;
        logic [DEN_W-1:0]        dd;
        md = r_area[CROSS_W-1] ? CROSS_W'(-r_area) : CROSS_W'(r_area);
        dd = {md, 1'b0};
        num[0] = r_numa;
        num[1] = NUM_W'(r_cv);
        num[2] = NUM_W'(r_cu);
        n_cell = '0;
        n_cell.valid = r_v2;
        n_cell.degen = r_degen;
        n_cell.den = dd;
        for (int i = 0; i < NLANE; i++) begin
            mag = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
            nn  = REM_W'({mag, {FRAC_SH{1'b0}}}) + REM_W'(md);
            n_cell.lane[i].rem  = nn;
            n_cell.lane[i].q    = '0;
            n_cell.lane[i].neg  = num[i][NUM_W-1] ^ r_area[CROSS_W-1];
            n_cell.lane[i].zero = (num[i] == '0);
            n_cell.lane[i].ovf  = DEN_W'(nn[REM_W-1:Q_W]) >= dd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= sub16(i_c_x, i_a_x);
            r_x1 <= sub16(i_b_x, i_a_x);
            r_x2 <= sub16(i_a_x, i_p_x);
            r_y0 <= sub16(i_c_y, i_a_y);
            r_y1 <= sub16(i_b_y, i_a_y);
            r_y2 <= sub16(i_a_y, i_p_y);
            r_m[0] <= r_x1 * r_y2;
            r_m[1] <= r_x2 * r_y1;
            r_m[2] <= r_x2 * r_y0;
            r_m[3] <= r_x0 * r_y2;
            r_m[4] <= r_x0 * r_y1;
            r_m[5] <= r_x1 * r_y0;
            r_cu    <= n_cu;
            r_cv    <= n_cv;
            r_area  <= n_area;
            r_numa  <= NUM_W'(n_area) - NUM_W'(n_cu) - NUM_W'(n_cv);
            r_degen <= n_degen;
        end
    end

    assign o_cell = r_cell;
endmodule

>>> hw/rtl/tbw_div_cell.sv
// one restoring division cell, resolves one quotient bit for all three weights
module tbw_div_cell import tbw_pkg::*; #(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell r_cell, n_cell;

    always_comb begin
        logic [WIDE_W-1:0] wr;
        logic [WIDE_W-1:0] ws;
        n_cell = i_cell;
        ws = WIDE_W'(i_cell.den) << K;
        for (int i = 0; i < NLANE; i++) begin
            wr = WIDE_W'(i_cell.lane[i].rem);
            if (wr >= ws) begin
                n_cell.lane[i].rem  = REM_W'(wr - ws);
                n_cell.lane[i].q[K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

>>> hw/rtl/triangle_barycentric_weights.sv
// top level: barycentric weights with a pipelined chain of division cells
//
// channel  direction  handshake                      payload
// in       slave      i_in_valid / o_in_ready         i_a_x .. i_p_y
// out      master     o_out_valid / i_out_ready       o_weight_a/b/c, o_degenerate
// config   write      i_area_threshold_we             i_area_threshold
//
// one item per cycle unless a stalled output holds the pipeline; 4 setup stages, 33 divider cells, 1 output
// the divider chain resolves one quotient bit per cell for the three weights at once
// synchronous active-low reset empties the pipeline and sets the threshold to 3
// a stalled output freezes the whole pipeline; ready is high whenever the output is free
module triangle_barycentric_weights import tbw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_p_x,
    input  logic signed [COORD_W-1:0] i_p_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [W_W-1:0]     o_weight_a,
    output logic signed [W_W-1:0]     o_weight_b,
    output logic signed [W_W-1:0]     o_weight_c,
    output logic                      o_degenerate,
    input  logic                      i_area_threshold_we,
    input  logic [THR_W-1:0]          i_area_threshold
);
    logic [THR_W-1:0] r_area_threshold;
    logic             w_en;
    t_cell            w_c [Q_W+1];
    logic             r_out_valid;
    logic [W_W-1:0]   r_wa, r_wb, r_wc;
    logic             r_degen;

    assign w_en = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_threshold <= THR_RESET;
        end else if (i_area_threshold_we) begin
            r_area_threshold <= i_area_threshold;
        end
    end

    tbw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_p_x   (i_p_x),
        .i_p_y   (i_p_y),
        .i_thr   (r_area_threshold),
        .o_cell  (w_c[0])
    );

    for (genvar j = 0; j < Q_W; j++) begin : g_cell
        tbw_div_cell #(.K(Q_W - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_c[j]),
            .o_cell  (w_c[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_c[Q_W].valid;
            r_degen     <= w_c[Q_W].degen;
            if (w_c[Q_W].degen) begin
                r_wa <= W_W'(-ONE_FX);
                r_wb <= ONE_FX;
                r_wc <= ONE_FX;
            end else begin
                r_wa <= fmt_weight(w_c[Q_W].lane[0]);
                r_wb <= fmt_weight(w_c[Q_W].lane[1]);
                r_wc <= fmt_weight(w_c[Q_W].lane[2]);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight_a   = r_wa;
    assign o_weight_b   = r_wb;
    assign o_weight_c   = r_wc;
    assign o_degenerate = r_degen;
endmodule

>>> hw/rtl/tbw_checker.sv
// port-level checks for the barycentric weight block
module tbw_checker import tbw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [W_W-1:0] o_weight_a,
    input logic signed [W_W-1:0] o_weight_b,
    input logic signed [W_W-1:0] o_weight_c,
    input logic                  o_degenerate
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_weight_a) && $stable(o_degenerate))
        else $error("result dropped while stalled");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_weight_a == -ONE_FX && o_weight_b == ONE_FX
            && o_weight_c == ONE_FX)
        else $error("degenerate weights wrong");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input blocked with free output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

bind triangle_barycentric_weights tbw_checker u_tbw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_weight_a   (o_weight_a),
    .o_weight_b   (o_weight_b),
    .o_weight_c   (o_weight_c),
    .o_degenerate (o_degenerate)
);

>>> tb/sv/tbw_weight_checker.sv
// checker for the barycentric weight block: predicts each transfer and compares results
module tbw_weight_checker import tbw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_p_x,
    input  logic signed [COORD_W-1:0] i_p_y,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [W_W-1:0]     i_weight_a,
    input  logic signed [W_W-1:0]     i_weight_b,
    input  logic signed [W_W-1:0]     i_weight_c,
    input  logic                      i_degenerate,
    input  logic                      i_thr_we,
    input  logic [THR_W-1:0]          i_thr,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [W_W-1:0] wa;
        logic signed [W_W-1:0] wb;
        logic signed [W_W-1:0] wc;
        logic                  degen;
    } t_weights;

    t_weights         expected_weights[$];
    logic [THR_W-1:0] area_thr;

    assign o_pending = expected_weights.size();

    // rounded num/den in 16 fractional bits, ties away from zero, saturated
    function automatic logic [W_W-1:0] scaled_ratio(longint num, longint den);
        longint unsigned mn, md, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        if (num == 0) return '0;
        mn = longint'(num < 0 ? -num : num) * 64'd65536;
        md = longint'(den < 0 ? -den : den);
        q = (2 * mn + md) / (2 * md);
        if (!neg) return (q > 64'h7FFF_FFFF) ? SAT_POS : q[W_W-1:0];
        if (q > 64'h8000_0000) return SAT_NEG;
        return W_W'(-q);
    endfunction

    function automatic t_weights barycentric_weights(longint ax, longint ay, longint bx,
                                                     longint by, longint cx, longint cy,
                                                     longint px, longint py,
                                                     logic [THR_W-1:0] thr);
        longint   x0, x1, x2, y0, y1, y2, cu, cv, area, mag;
        t_weights w;
        x0 = cx - ax; x1 = bx - ax; x2 = ax - px;
        y0 = cy - ay; y1 = by - ay; y2 = ay - py;
        cu = x1 * y2 - x2 * y1;
        cv = x2 * y0 - x0 * y2;
        area = x0 * y1 - x1 * y0;
        mag = area < 0 ? -area : area;
        if (area == 0 || mag < longint'(thr)) begin
            w.wa = -ONE_FX;
            w.wb = ONE_FX;
            w.wc = ONE_FX;
            w.degen = 1'b1;
        end else begin
            w.wa = scaled_ratio(area - cu - cv, area);
            w.wb = scaled_ratio(cv, area);
            w.wc = scaled_ratio(cu, area);
            w.degen = 1'b0;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_weights e;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            area_thr <= THR_RESET;
            o_fail_count <= 0;
            expected_weights.delete();
        end else begin
            if (i_thr_we) area_thr <= i_thr;
            if (i_in_valid && i_in_ready)
                expected_weights = {expected_weights,
                    barycentric_weights(longint'(i_a_x), longint'(i_a_y),
                                        longint'(i_b_x), longint'(i_b_y),
                                        longint'(i_c_x), longint'(i_c_y),
                                        longint'(i_p_x), longint'(i_p_y), area_thr)};
            if (i_out_valid && i_out_ready) begin
                if (expected_weights.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    e = expected_weights.pop_front();
                    if (i_weight_a !== e.wa) begin
                        $error("weight_a: expected %0d, got %0d", e.wa, i_weight_a);
                        errs++;
                    end
                    if (i_weight_b !== e.wb) begin
                        $error("weight_b: expected %0d, got %0d", e.wb, i_weight_b);
                        errs++;
                    end
                    if (i_weight_c !== e.wc) begin
                        $error("weight_c: expected %0d, got %0d", e.wc, i_weight_c);
                        errs++;
                    end
                    if (i_degenerate !== e.degen) begin
                        $error("degenerate: expected %0b, got %0b", e.degen, i_degenerate);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

>>> tb/sv/triangle_barycentric_weights_tb.sv
// testbench top: stimulus, idling phases, threshold settings and the verdict
module triangle_barycentric_weights_tb;
    import tbw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 45;
    localparam int RANDOM_PER_PHASE = 350;

    typedef logic signed [COORD_W-1:0] t_coord;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_coord                a_x = '0, a_y = '0, b_x = '0, b_y = '0;
    t_coord                c_x = '0, c_y = '0, p_x = '0, p_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [W_W-1:0] weight_a, weight_b, weight_c;
    logic                  degenerate;
    logic                  thr_we = 1'b0;
    logic [THR_W-1:0]      thr = '0;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    triangle_barycentric_weights i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_a_x(a_x), .i_a_y(a_y), .i_b_x(b_x), .i_b_y(b_y),
        .i_c_x(c_x), .i_c_y(c_y), .i_p_x(p_x), .i_p_y(p_y),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_weight_a(weight_a), .o_weight_b(weight_b), .o_weight_c(weight_c),
        .o_degenerate(degenerate),
        .i_area_threshold_we(thr_we), .i_area_threshold(thr)
    );

    tbw_weight_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_a_x(a_x), .i_a_y(a_y), .i_b_x(b_x), .i_b_y(b_y),
        .i_c_x(c_x), .i_c_y(c_y), .i_p_x(p_x), .i_p_y(p_y),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_weight_a(weight_a), .i_weight_b(weight_b), .i_weight_c(weight_c),
        .i_degenerate(degenerate),
        .i_thr_we(thr_we), .i_thr(thr),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk)
        out_ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("triangle_barycentric_weights_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_triangle(int ax, int ay, int bx, int by,
                                 int cx, int cy, int px, int py);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        {a_x, a_y, b_x, b_y} = {t_coord'(ax), t_coord'(ay), t_coord'(bx), t_coord'(by)};
        {c_x, c_y, p_x, p_y} = {t_coord'(cx), t_coord'(cy), t_coord'(px), t_coord'(py)};
        in_valid = 1'b1;
        do begin
            @(posedge i_clk);
            taken = in_ready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        thr = value;
        thr_we = 1'b1;
        @(negedge i_clk);
        thr_we = 1'b0;
    endtask

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    function automatic t_coord near(t_coord base, int span);
        return t_coord'(int'(base) + $urandom_range(2 * span) - span);
    endfunction

    task automatic send_random_triangle();
        t_coord ax, ay, bx, by, cx, cy, px, py;
        int     dx, dy;
        ax = t_coord'($urandom_range(32000) - 16000);
        ay = t_coord'($urandom_range(32000) - 16000);
        case ($urandom_range(9))
            0, 1, 2: begin
                {ax, ay, bx, by} = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                {cx, cy, px, py} = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            end
            3, 4, 5: begin
                {bx, by, cx, cy} = {near(ax, 8), near(ay, 8), near(ax, 8), near(ay, 8)};
                {px, py} = {near(ax, 40), near(ay, 40)};
            end
            6, 7: begin
                {bx, by, cx, cy} = {near(ax, 8000), near(ay, 8000), near(ax, 8000), near(ay, 8000)};
                px = t_coord'((int'(ax) + int'(bx) + int'(cx)) / 3);
                py = t_coord'((int'(ay) + int'(by) + int'(cy)) / 3);
            end
            8: begin
                dx = $urandom_range(400) - 200;
                dy = $urandom_range(400) - 200;
                bx = t_coord'(int'(ax) + dx); by = t_coord'(int'(ay) + dy);
                cx = t_coord'(int'(ax) + 2 * dx); cy = t_coord'(int'(ay) + 2 * dy);
                {px, py} = {rand_coord(), rand_coord()};
            end
            default: begin
                {bx, by, cx, cy} = {near(ax, 2), near(ay, 2), near(ax, 2), near(ay, 2)};
                {px, py} = {rand_coord(), rand_coord()};
            end
        endcase
        send_triangle(int'(ax), int'(ay), int'(bx), int'(by),
                      int'(cx), int'(cy), int'(px), int'(py));
    endtask

    initial begin
        int lo, hi;
        lo = -32768;
        hi = 32767;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // corners at the coordinate extremes
        send_triangle(lo, lo, hi, lo, lo, hi, hi, hi);
        send_triangle(hi, hi, lo, hi, hi, lo, lo, lo);
        send_triangle(lo, lo, hi, hi, hi, lo, 0, 0);
        send_triangle(hi, lo, lo, lo, hi, hi, lo, hi);
        // zero area and the threshold boundary
        send_triangle(0, 0, 0, 0, 0, 0, 5, 5);
        send_triangle(lo, lo, 0, 0, hi, hi, 1, 2);
        send_triangle(0, 0, 1, 0, 0, 2, 0, 0);
        send_triangle(0, 0, 1, 0, 0, 3, 0, 0);
        send_triangle(0, 0, 0, 3, 1, 0, 1, 1);
        // point on corners and inside
        send_triangle(0, 0, 160, 0, 0, 160, 0, 0);
        send_triangle(0, 0, 160, 0, 0, 160, 160, 0);
        send_triangle(0, 0, 160, 0, 0, 160, 0, 160);
        send_triangle(0, 0, 160, 0, 0, 160, 53, 53);
        send_triangle(-100, -100, 100, -100, 0, 100, -1, 7);
        // tiny area, far point: both saturations
        send_triangle(0, 0, 1, 0, 0, 3, hi, hi);
        send_triangle(0, 0, 1, 0, 0, 3, lo, lo);
        send_triangle(0, 0, 0, 3, 1, 0, hi, lo);
        send_triangle(0, 0, 0, 3, 1, 0, lo, hi);
        send_triangle(hi, hi, hi, hi - 2, hi - 2, hi, lo, lo);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_threshold('0);
                1: write_threshold({THR_W{1'b1}});
                2: write_threshold(THR_W'($urandom_range(1048575)));
                3: write_threshold(THR_W'(256));
                default: write_threshold(THR_RESET);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 0) begin
                send_triangle(0, 0, 0, 0, 0, 0, 1, 1);
                send_triangle(0, 0, 1, 0, 0, 1, 1, 1);
            end
            repeat (RANDOM_PER_PHASE) send_random_triangle();
        end
        in_valid = 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("triangle_barycentric_weights_tb: clean");
        else
            $display("triangle_barycentric_weights_tb: errors");
        $finish;
    end

endmodule
